>>> sv/priority_thread_scheduler_defines.svh
// assertion macros for the priority thread scheduler
// no dependencies
`ifndef PRIORITY_THREAD_SCHEDULER_DEFINES_SVH
`define PRIORITY_THREAD_SCHEDULER_DEFINES_SVH

// assert a property on every rising clock edge outside reset
`define PTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// assert an implication on every rising clock edge outside reset
`define PTS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> sv/pts_pkg.sv
// shared types and constants of the priority thread scheduler
// no dependencies
package pts_pkg;

  localparam int unsigned ThreadSlots = 8;
  localparam int unsigned EventSlots  = 8;
  localparam int unsigned SlotW       = $clog2(ThreadSlots);
  localparam int unsigned EvW         = $clog2(EventSlots);
  localparam int unsigned CntW        = $clog2(ThreadSlots + 1);
  localparam int unsigned ECntW       = $clog2(EventSlots + 1);

  localparam logic [2:0] KindTick     = 3'd0;
  localparam logic [2:0] KindAdd      = 3'd1;
  localparam logic [2:0] KindKillId   = 3'd2;
  localparam logic [2:0] KindKillSelf = 3'd3;
  localparam logic [2:0] KindSleep    = 3'd4;
  localparam logic [2:0] KindAddEvent = 3'd5;
  localparam logic [2:0] KindBlock    = 3'd6;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatFull    = 2'd1;
  localparam logic [1:0] StatLast    = 2'd2;
  localparam logic [1:0] StatNoMatch = 2'd3;

  // one thread table entry
  typedef struct packed {
    logic [7:0]       prio;
    logic [7:0]       ident;
    logic [31:0]      wake;
    logic [SlotW-1:0] nxt;
    logic [SlotW-1:0] prv;
  } thread_t;

  // one periodic event entry
  typedef struct packed {
    logic [31:0] period;
    logic [31:0] due;
  } event_t;

endpackage

>>> sv/priority_thread_scheduler.sv
// The time from the accepting edge to out_valid_o is set by the serial walk of the thread memory
// (one entry read per cycle), plus the event sweep on a tick. One request is in flight at a time.
// The result register frees once taken, and only then is the next request accepted.
// Reset (asynchronous, active low) clears the state, marks, tick, live and event counts, ring
// pointers and result valid; the thread and event memories keep undefined contents until written.
// depends on pts_pkg and priority_thread_scheduler_defines.svh
`include "priority_thread_scheduler_defines.svh"

module priority_thread_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  thread_id_i,
  input  logic [7:0]  priority_req_i,
  input  logic [31:0] duration_i,
  input  logic [31:0] period_i,
  input  logic        blocked_flag_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [2:0]  running_slot_o,
  output logic [7:0]  running_id_o,
  output logic [7:0]  fired_mask_o,
  output logic [3:0]  thread_count_o,
  output logic [31:0] time_now_o
);

  localparam int unsigned SW = pts_pkg::SlotW;
  localparam int unsigned EW = pts_pkg::EvW;
  localparam int unsigned TS = pts_pkg::ThreadSlots;
  localparam int unsigned ES = pts_pkg::EventSlots;

  typedef enum logic [10:0] {
    StIdle  = 11'b00000000001,
    StRead  = 11'b00000000010,
    StWake  = 11'b00000000100,
    StEvent = 11'b00000001000,
    StPick  = 11'b00000010000,
    StKill  = 11'b00000100000,
    StLink  = 11'b00001000000,
    StFix   = 11'b00010000000,
    StBlock = 11'b00100000000,
    StDone  = 11'b01000000000,
    StOut   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  // thread and event memories, registered read
  pts_pkg::thread_t tmem [TS];
  pts_pkg::event_t  emem [ES];
  pts_pkg::thread_t trd_q;
  pts_pkg::event_t  erd_q;
  logic [SW-1:0]    traddr;
  logic [EW-1:0]    eraddr;
  logic             twe, ewe;
  logic [SW-1:0]    twaddr;
  logic [EW-1:0]    ewaddr;
  pts_pkg::thread_t twdata;
  pts_pkg::event_t  ewdata;

  always_ff @(posedge clk_i) begin
    if (twe) tmem[twaddr] <= twdata;
    if (ewe) emem[ewaddr] <= ewdata;
    trd_q <= tmem[traddr];
    erd_q <= emem[eraddr];
  end

  // control state
  logic [31:0]     ticks_q, ticks_d;
  logic [TS-1:0]   alive_q, alive_d, asleep_q, asleep_d, blk_q, blk_d;
  logic [SW-1:0]   head_q, head_d, tail_q, tail_d, cur_q, cur_d;
  logic [pts_pkg::CntW-1:0]  live_q, live_d;
  logic [pts_pkg::ECntW-1:0] evc_q, evc_d;

  // request registers and walk state
  logic [2:0]      kind_q;
  logic [7:0]      id_q, prio_q;
  logic [31:0]     dur_q;
  logic            bflag_q;
  logic [SW-1:0]   it_q, it_d, chosen_q, chosen_d, ks_q, ks_d;
  logic [pts_pkg::CntW-1:0]  n_q, n_d;
  logic [pts_pkg::ECntW-1:0] ei_q, ei_d;
  logic [8:0]      best_q, best_d;
  logic [1:0]      stat_q, stat_d;
  logic [7:0]      fired_q, fired_d;
  logic [1:0]      fix_q, fix_d;
  pts_pkg::thread_t kent_q, kent_d;

  // result register
  logic            ov_q;
  logic [1:0]      ost_q;
  logic [SW-1:0]   oslot_q;
  logic [7:0]      oid_q, ofired_q;
  logic [3:0]      ocnt_q;
  logic [31:0]     otime_q;

  assign in_ready_o     = (state_q == StIdle) && !ov_q;
  assign out_valid_o    = ov_q;
  assign status_o       = ost_q;
  assign running_slot_o = 3'(oslot_q);
  assign running_id_o   = oid_q;
  assign fired_mask_o   = ofired_q;
  assign thread_count_o = ocnt_q;
  assign time_now_o     = otime_q;

  logic accept;
  assign accept = in_valid_i && in_ready_o;

  // lowest free slot
  logic [SW-1:0] free_slot;
  always_comb begin
    free_slot = '0;
    for (int i = TS - 1; i >= 0; i--) begin
      if (!alive_q[i]) free_slot = SW'(i);
    end
  end

  // result capture strobe
  logic done_fire;

  always_comb begin
    state_d  = state_q;
    ticks_d  = ticks_q;
    alive_d  = alive_q;
    asleep_d = asleep_q;
    blk_d    = blk_q;
    head_d   = head_q;
    tail_d   = tail_q;
    cur_d    = cur_q;
    live_d   = live_q;
    evc_d    = evc_q;
    it_d     = it_q;
    chosen_d = chosen_q;
    ks_d     = ks_q;
    n_d      = n_q;
    ei_d     = ei_q;
    best_d   = best_q;
    stat_d   = stat_q;
    fired_d  = fired_q;
    fix_d    = fix_q;
    kent_d   = kent_q;
    traddr   = it_q;
    eraddr   = EW'(ei_q);
    twe      = 1'b0;
    ewe      = 1'b0;
    twaddr   = it_q;
    ewaddr   = EW'(ei_q);
    twdata   = trd_q;
    ewdata   = erd_q;
    done_fire = 1'b0;

    unique case (state_q)
      StIdle: begin
        traddr = cur_q;
        eraddr = '0;
        stat_d = pts_pkg::StatOk;
        fired_d = '0;
        n_d = '0;
        ei_d = '0;
        best_d = 9'd256;
        chosen_d = cur_q;
        fix_d = '0;
        if (accept) begin
          state_d = StDone;
          case (kind_i) inside
            pts_pkg::KindTick: state_d = (live_q != 0) ? StRead : StEvent;
            pts_pkg::KindAdd: begin
              if (live_q >= pts_pkg::CntW'(TS)) stat_d = pts_pkg::StatFull;
              else state_d = StLink;
            end
            pts_pkg::KindKillId, pts_pkg::KindKillSelf: begin
              if (live_q <= 1) stat_d = pts_pkg::StatLast;
              else if (kind_i == pts_pkg::KindKillSelf && !alive_q[cur_q])
                stat_d = pts_pkg::StatNoMatch;
              else state_d = StRead;
            end
            pts_pkg::KindSleep: begin
              if (live_q == 0) stat_d = pts_pkg::StatNoMatch;
              else state_d = StRead;
            end
            pts_pkg::KindAddEvent: begin
              if (evc_q >= pts_pkg::ECntW'(ES)) stat_d = pts_pkg::StatFull;
              else begin
                ewe = 1'b1;
                ewaddr = EW'(evc_q);
                ewdata.period = period_i;
                ewdata.due = ticks_q + period_i;
                evc_d = evc_q + 1'b1;
              end
            end
            pts_pkg::KindBlock: begin
              stat_d = pts_pkg::StatNoMatch;
              it_d = '0;
              traddr = '0;
              state_d = StBlock;
            end
            default: ;
          endcase
        end
      end

      // current entry is in trd_q: act, then start a ring walk at its successor (kill-self goes to unlink it instead)
      StRead: begin
        it_d = trd_q.nxt;
        traddr = trd_q.nxt;
        case (kind_q)
          pts_pkg::KindTick: begin
            kent_d = trd_q;
            state_d = StWake;
          end
          pts_pkg::KindKillId: begin
            stat_d = pts_pkg::StatNoMatch;
            state_d = StKill;
          end
          pts_pkg::KindKillSelf: begin
            kent_d = trd_q;
            ks_d = cur_q;
            fix_d = '0;
            state_d = StFix;
            traddr = trd_q.prv;
          end
          default: begin
            twe = 1'b1;
            twaddr = cur_q;
            twdata = trd_q;
            twdata.wake = dur_q + ticks_q;
            asleep_d[cur_q] = 1'b1;
            state_d = StPick;
          end
        endcase
      end

      // wake sleepers, stopping at the running slot
      StWake: begin
        traddr = trd_q.nxt;
        it_d = trd_q.nxt;
        n_d = n_q + 1'b1;
        if (it_q == cur_q || n_q >= live_q) begin
          state_d = StEvent;
        end else begin
          if (trd_q.wake == ticks_q) asleep_d[it_q] = 1'b0;
          if (n_q + 1'b1 >= live_q || trd_q.nxt == cur_q) state_d = StEvent;
        end
      end

      // fire due events; erd_q holds event ei_q
      StEvent: begin
        eraddr = EW'(ei_q + 1'b1);
        if (ei_q >= evc_q) begin
          // time advances, then the pick walks from the running slot's successor
          ticks_d = ticks_q + 1'b1;
          traddr = kent_q.nxt;
          it_d = kent_q.nxt;
          n_d = '0;
          state_d = (live_q != 0) ? StPick : StDone;
        end else begin
          // event ei_q is due: flag it and rearm one period later
          if (erd_q.due == ticks_q) begin
            if (ei_q < 8) fired_d[3'(ei_q)] = 1'b1;
            ewe = 1'b1;
            ewdata.due = ticks_q + erd_q.period;
          end
          ei_d = ei_q + 1'b1;
        end
      end

      // scan live_count-1 entries from the successor
      StPick: begin
        traddr = trd_q.nxt;
        it_d = trd_q.nxt;
        if (n_q + 1'b1 >= live_q) begin
          cur_d = chosen_q;
          state_d = StDone;
        end else begin
          if (!asleep_q[it_q] && !blk_q[it_q] && {1'b0, trd_q.prio} < best_q) begin
            best_d = {1'b0, trd_q.prio};
            chosen_d = it_q;
          end
          n_d = n_q + 1'b1;
        end
      end

      // search other threads for the id
      StKill: begin
        traddr = trd_q.nxt;
        it_d = trd_q.nxt;
        if (n_q + 1'b1 >= live_q) begin
          state_d = StDone;
        end else if (trd_q.ident == id_q) begin
          stat_d = pts_pkg::StatOk;
          kent_d = trd_q;
          ks_d = it_q;
          fix_d = '0;
          traddr = trd_q.prv;
          state_d = StFix;
        end else begin
          n_d = n_q + 1'b1;
        end
      end

      // unlink ks_q: patch prev then next
      StFix: begin
        fix_d = fix_q + 1'b1;
        case (fix_q)
          2'd0: traddr = kent_q.prv;
          2'd1: begin
            twe = 1'b1;
            twaddr = kent_q.prv;
            twdata = trd_q;
            twdata.nxt = kent_q.nxt;
            traddr = kent_q.nxt;
          end
          2'd2: ;
          default: begin
            twe = 1'b1;
            twaddr = kent_q.nxt;
            twdata = trd_q;
            twdata.prv = kent_q.prv;
            if (kent_q.nxt == kent_q.prv) twdata.nxt = kent_q.nxt;
            alive_d[ks_q] = 1'b0;
            blk_d[ks_q] = 1'b0;
            live_d = live_q - 1'b1;
            if (ks_q == tail_q) tail_d = kent_q.prv;
            if (ks_q == head_q) head_d = kent_q.nxt;
            if (kind_q == pts_pkg::KindKillSelf) begin
              traddr = kent_q.nxt;
              it_d = kent_q.nxt;
              n_d = '0;
              state_d = StLink;
              fix_d = 2'd3;
            end else begin
              state_d = StDone;
            end
          end
        endcase
      end

      // add: write the new entry, patch tail then head; kill-self: wait a read
      StLink: begin
        if (kind_q == pts_pkg::KindKillSelf) begin
          traddr = it_q;
          state_d = StPick;
          n_d = '0;
        end else begin
          fix_d = fix_q + 1'b1;
          case (fix_q)
            2'd0: begin
              twe = 1'b1;
              ks_d = (live_q == 0) ? '0 : free_slot;
              twaddr = (live_q == 0) ? '0 : free_slot;
              twdata.prio = prio_q;
              twdata.ident = id_q;
              twdata.wake = '0;
              twdata.nxt = (live_q == 0) ? '0 : head_q;
              twdata.prv = (live_q == 0) ? '0 : tail_q;
              traddr = tail_q;
              if (live_q == 0) begin
                head_d = '0;
                cur_d = '0;
              end
            end
            // tail entry is in trd_q; a one-entry ring also gets its prev here
            2'd1: begin
              twe = 1'b1;
              twaddr = tail_q;
              twdata = trd_q;
              twdata.nxt = ks_q;
              if (tail_q == head_q) twdata.prv = ks_q;
              traddr = head_q;
            end
            // head entry is in trd_q
            default: begin
              twe = 1'b1;
              twaddr = head_q;
              twdata = trd_q;
              twdata.prv = ks_q;
            end
          endcase
          if ((fix_q == 2'd0 && live_q == 0) || (fix_q == 2'd1 && tail_q == head_q) ||
              fix_q >= 2'd2) begin
            alive_d[ks_d] = 1'b1;
            asleep_d[ks_d] = 1'b0;
            blk_d[ks_d] = 1'b0;
            live_d = live_q + 1'b1;
            tail_d = ks_d;
            state_d = StDone;
          end
        end
      end

      // lowest matching live slot; trd_q holds entry it_q
      StBlock: begin
        traddr = SW'(it_q + 1'b1);
        it_d = SW'(it_q + 1'b1);
        if (alive_q[it_q] && trd_q.ident == id_q) begin
          blk_d[it_q] = bflag_q;
          stat_d = pts_pkg::StatOk;
          state_d = StDone;
        end else if (it_q == SW'(TS - 1)) begin
          state_d = StDone;
        end
      end

      // read the running entry for its id
      StDone: begin
        traddr = cur_q;
        state_d = StOut;
      end

      StOut: begin
        done_fire = 1'b1;
        state_d = StIdle;
      end

      default: state_d = StIdle;
    endcase
  end

  // register update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ticks_q  <= '0;
      alive_q  <= '0;
      asleep_q <= '0;
      blk_q    <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      cur_q    <= '0;
      live_q   <= '0;
      evc_q    <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      ticks_q  <= ticks_d;
      alive_q  <= alive_d;
      asleep_q <= asleep_d;
      blk_q    <= blk_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      cur_q    <= cur_d;
      live_q   <= live_d;
      evc_q    <= evc_d;
      if (done_fire) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  // request capture and walk registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_i;
      id_q    <= thread_id_i;
      prio_q  <= priority_req_i;
      dur_q   <= duration_i;
      bflag_q <= blocked_flag_i;
    end
    it_q     <= it_d;
    chosen_q <= chosen_d;
    ks_q     <= ks_d;
    n_q      <= n_d;
    ei_q     <= ei_d;
    best_q   <= best_d;
    stat_q   <= stat_d;
    fired_q  <= fired_d;
    fix_q    <= fix_d;
    kent_q   <= kent_d;
    if (done_fire) begin
      ost_q    <= stat_q;
      oslot_q  <= (live_q != 0) ? cur_q : '0;
      oid_q    <= (live_q != 0) ? trd_q.ident : 8'd0;
      ofired_q <= fired_q;
      ocnt_q   <= 4'(live_q);
      otime_q  <= ticks_q;
    end
  end

  `PTS_ASSERT_IMP(a_ready_idle, in_ready_o, state_q == StIdle && !ov_q, "ready outside idle")
  `PTS_ASSERT_IMP(a_hold_out, ov_q && !out_ready_i, ##1 ov_q, "result dropped")
  `PTS_ASSERT(a_live_range, live_q <= pts_pkg::CntW'(TS), "live count overflow")
  `PTS_ASSERT(a_evc_range, evc_q <= pts_pkg::ECntW'(ES), "event count overflow")

endmodule

>>> tb/tb_priority_thread_scheduler.sv
// self-checking testbench for the priority thread scheduler
// depends on pts_pkg and the priority_thread_scheduler rtl
`timescale 1ns / 100ps

module tb_priority_thread_scheduler;

  localparam logic [2:0] KindNop = 3'd7;
  localparam int unsigned NoPrio = 256;

  // expected result of one request
  typedef struct {
    logic [1:0]  status;
    logic [2:0]  slot;
    logic [7:0]  id;
    logic [7:0]  fired;
    logic [3:0]  count;
    logic [31:0] now;
  } sched_result_t;

  // one request with an optional typed-in answer
  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [31:0] dur;
    logic [31:0] per;
    logic        bflag;
    bit          has_fixed;
    logic [1:0]  fixed_status;
    logic [3:0]  fixed_count;
  } sched_req_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  kind_i;
  logic [7:0]  thread_id_i;
  logic [7:0]  priority_req_i;
  logic [31:0] duration_i;
  logic [31:0] period_i;
  logic        blocked_flag_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [2:0]  running_slot_o;
  logic [7:0]  running_id_o;
  logic [7:0]  fired_mask_o;
  logic [3:0]  thread_count_o;
  logic [31:0] time_now_o;

  priority_thread_scheduler u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .thread_id_i    (thread_id_i),
    .priority_req_i (priority_req_i),
    .duration_i     (duration_i),
    .period_i       (period_i),
    .blocked_flag_i (blocked_flag_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .running_slot_o (running_slot_o),
    .running_id_o   (running_id_o),
    .fired_mask_o   (fired_mask_o),
    .thread_count_o (thread_count_o),
    .time_now_o     (time_now_o)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // scheduler shadow state
  logic [31:0] sys_ticks;
  bit          alive[8];
  bit          asleep[8];
  bit          blocked[8];
  logic [7:0]  prio_tab[8];
  logic [7:0]  ident_tab[8];
  logic [31:0] wake_tab[8];
  logic [2:0]  nxt_tab[8];
  logic [2:0]  prv_tab[8];
  logic [2:0]  head, tail, cur;
  int unsigned n_live, n_events;
  logic [31:0] ev_period[8];
  logic [31:0] ev_due[8];

  sched_result_t pending_results[$];
  sched_req_t    directed_reqs[$];
  int unsigned   mismatches;
  bit            quiet_phase;
  bit            hold_off;
  bit            stim_done;

  function automatic void reschedule();
    int unsigned best;
    logic [2:0]  chosen, it;
    best = NoPrio;
    chosen = cur;
    it = nxt_tab[cur];
    if (n_live == 0) return;
    for (int n = 0; n + 1 < n_live; n++) begin
      if (!asleep[it] && !blocked[it] && prio_tab[it] < best) begin
        best = prio_tab[it];
        chosen = it;
      end
      it = nxt_tab[it];
    end
    cur = chosen;
  endfunction

  function automatic void drop_slot(logic [2:0] s);
    logic [2:0] p, q;
    p = prv_tab[s];
    q = nxt_tab[s];
    nxt_tab[p] = q;
    prv_tab[q] = p;
    alive[s] = 0;
    blocked[s] = 0;
    n_live--;
    if (s == tail) tail = p;
    if (s == head) head = q;
  endfunction

  // advance the shadow scheduler by one request and return its answer
  function automatic sched_result_t schedule_op(sched_req_t r);
    sched_result_t res;
    logic [1:0]    st;
    logic [7:0]    fired;
    logic [2:0]    it;
    st = pts_pkg::StatOk;
    fired = '0;
    case (r.kind)
      pts_pkg::KindTick: begin
        if (n_live > 0) begin
          it = nxt_tab[cur];
          for (int n = 0; n < n_live && it != cur; n++) begin
            if (wake_tab[it] == sys_ticks) asleep[it] = 0;
            it = nxt_tab[it];
          end
        end
        for (int i = 0; i < n_events; i++) begin
          if (ev_due[i] == sys_ticks) begin
            fired[i] = 1'b1;
            ev_due[i] = sys_ticks + ev_period[i];
          end
        end
        sys_ticks++;
        reschedule();
      end
      pts_pkg::KindAdd: begin
        if (n_live >= pts_pkg::ThreadSlots) begin
          st = pts_pkg::StatFull;
        end else begin
          if (n_live == 0) begin
            it = 0;
            nxt_tab[0] = 0;
            prv_tab[0] = 0;
            head = 0;
            cur = 0;
          end else begin
            it = 0;
            for (int i = 7; i >= 0; i--) if (!alive[i]) it = 3'(i);
            prv_tab[it] = tail;
            nxt_tab[it] = head;
            nxt_tab[tail] = it;
            prv_tab[head] = it;
          end
          prio_tab[it] = r.prio;
          ident_tab[it] = r.id;
          asleep[it] = 0;
          blocked[it] = 0;
          alive[it] = 1;
          n_live++;
          tail = it;
        end
      end
      pts_pkg::KindKillId: begin
        if (n_live <= 1) begin
          st = pts_pkg::StatLast;
        end else begin
          st = pts_pkg::StatNoMatch;
          it = nxt_tab[cur];
          for (int n = 0; n + 1 < n_live; n++) begin
            if (ident_tab[it] == r.id) begin
              drop_slot(it);
              st = pts_pkg::StatOk;
              break;
            end
            it = nxt_tab[it];
          end
        end
      end
      pts_pkg::KindKillSelf: begin
        if (n_live <= 1) st = pts_pkg::StatLast;
        else if (!alive[cur]) st = pts_pkg::StatNoMatch;
        else begin
          drop_slot(cur);
          reschedule();
        end
      end
      pts_pkg::KindSleep: begin
        if (n_live == 0) st = pts_pkg::StatNoMatch;
        else begin
          wake_tab[cur] = r.dur + sys_ticks;
          asleep[cur] = 1;
          reschedule();
        end
      end
      pts_pkg::KindAddEvent: begin
        if (n_events >= pts_pkg::EventSlots) st = pts_pkg::StatFull;
        else begin
          ev_period[n_events] = r.per;
          ev_due[n_events] = sys_ticks + r.per;
          n_events++;
        end
      end
      pts_pkg::KindBlock: begin
        st = pts_pkg::StatNoMatch;
        for (int i = 0; i < 8; i++) begin
          if (alive[i] && ident_tab[i] == r.id) begin
            blocked[i] = r.bflag;
            st = pts_pkg::StatOk;
            break;
          end
        end
      end
      default: ;
    endcase
    res.status = st;
    res.slot = n_live ? cur : 3'd0;
    res.id = n_live ? ident_tab[cur] : 8'd0;
    res.fired = fired;
    res.count = n_live[3:0];
    res.now = sys_ticks;
    return res;
  endfunction

  function automatic sched_req_t make_req(logic [2:0] k, logic [7:0] id, logic [7:0] p,
                                          logic [31:0] d, logic [31:0] pe, logic b);
    sched_req_t r;
    r.kind = k;
    r.id = id;
    r.prio = p;
    r.dur = d;
    r.per = pe;
    r.bflag = b;
    r.has_fixed = 0;
    r.fixed_status = '0;
    r.fixed_count = '0;
    return r;
  endfunction

  function automatic sched_req_t fixed_req(logic [2:0] k, logic [7:0] id, logic [7:0] p,
                                           logic [31:0] d, logic [31:0] pe,
                                           logic [1:0] st, logic [3:0] cnt);
    sched_req_t r;
    r = make_req(k, id, p, d, pe, 1'b0);
    r.has_fixed = 1;
    r.fixed_status = st;
    r.fixed_count = cnt;
    return r;
  endfunction

  // random request, mostly well formed around live ids
  function automatic sched_req_t rand_req();
    sched_req_t r;
    int unsigned sel;
    logic [7:0]  pick_id;
    pick_id = 8'($urandom_range(0, 11));
    if ($urandom_range(0, 9) == 0) pick_id = 8'($urandom);
    r = make_req(3'($urandom), pick_id, 8'($urandom), 32'($urandom_range(0, 6)),
                 32'($urandom_range(0, 9)), 1'($urandom));
    if ($urandom_range(0, 15) == 0) r.dur = $urandom;
    if ($urandom_range(0, 15) == 0) r.per = $urandom;
    if ($urandom_range(0, 3) == 0) r.prio = 8'($urandom_range(0, 3));
    sel = $urandom_range(0, 99);
    if (sel < 30) r.kind = pts_pkg::KindTick;
    else if (sel < 45) r.kind = pts_pkg::KindAdd;
    else if (sel < 53) r.kind = pts_pkg::KindKillId;
    else if (sel < 59) r.kind = pts_pkg::KindKillSelf;
    else if (sel < 72) r.kind = pts_pkg::KindSleep;
    else if (sel < 76) r.kind = pts_pkg::KindAddEvent;
    else if (sel < 95) r.kind = pts_pkg::KindBlock;
    return r;
  endfunction

  task automatic idle_burst(input int unsigned pct);
    if (!quiet_phase && $urandom_range(0, 99) < pct)
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
  endtask

  // offer one request and record its expected answer
  task automatic send_req(input sched_req_t r);
    sched_result_t res;
    idle_burst(25);
    kind_i = r.kind;
    thread_id_i = r.id;
    priority_req_i = r.prio;
    duration_i = r.dur;
    period_i = r.per;
    blocked_flag_i = r.bflag;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    res = schedule_op(r);
    if (r.has_fixed && (res.status != r.fixed_status || res.count != r.fixed_count))
      $display("directed row answer differs from shadow: st %0d cnt %0d", res.status,
               res.count);
    if (r.has_fixed) begin
      res.status = r.fixed_status;
      res.count = r.fixed_count;
    end
    pending_results.push_back(res);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // stimulus
  initial begin
    sched_req_t r;
    in_valid_i = 0;
    kind_i = '0;
    thread_id_i = '0;
    priority_req_i = '0;
    duration_i = '0;
    period_i = '0;
    blocked_flag_i = 0;
    rst_ni = 0;
    quiet_phase = 0;
    stim_done = 0;
    sys_ticks = '0;
    head = '0;
    tail = '0;
    cur = '0;
    n_live = 0;
    n_events = 0;
    for (int i = 0; i < 8; i++) begin
      alive[i] = 0;
      asleep[i] = 0;
      blocked[i] = 0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed table: empty table cases, extremes, full table, last thread
    directed_reqs.push_back(fixed_req(pts_pkg::KindSleep, 0, 0, 5, 0, pts_pkg::StatNoMatch, 0));
    directed_reqs.push_back(fixed_req(pts_pkg::KindKillSelf, 0, 0, 0, 0, pts_pkg::StatLast, 0));
    directed_reqs.push_back(fixed_req(pts_pkg::KindKillId, 0, 0, 0, 0, pts_pkg::StatLast, 0));
    directed_reqs.push_back(fixed_req(pts_pkg::KindBlock, 0, 0, 0, 0, pts_pkg::StatNoMatch, 0));
    directed_reqs.push_back(fixed_req(KindNop, 8'hff, 8'hff, '1, '1, pts_pkg::StatOk, 0));
    directed_reqs.push_back(fixed_req(pts_pkg::KindTick, 0, 0, 0, 0, pts_pkg::StatOk, 0));
    directed_reqs.push_back(fixed_req(pts_pkg::KindAdd, 8'hff, 8'hff, 0, 0, pts_pkg::StatOk, 1));
    directed_reqs.push_back(fixed_req(pts_pkg::KindKillSelf, 0, 0, 0, 0, pts_pkg::StatLast, 1));
    for (int i = 0; i < 7; i++)
      directed_reqs.push_back(make_req(pts_pkg::KindAdd, 8'(i), 8'(7 - i), 0, 0, 0));
    directed_reqs.push_back(fixed_req(pts_pkg::KindAdd, 8'h55, 0, 0, 0, pts_pkg::StatFull, 8));
    directed_reqs.push_back(make_req(pts_pkg::KindAddEvent, 0, 0, 0, 32'hffff_ffff, 0));
    directed_reqs.push_back(make_req(pts_pkg::KindAddEvent, 0, 0, 0, 0, 0));
    directed_reqs.push_back(make_req(pts_pkg::KindAddEvent, 0, 0, 0, 2, 0));
    directed_reqs.push_back(make_req(pts_pkg::KindBlock, 8'd6, 0, 0, 0, 1));
    directed_reqs.push_back(make_req(pts_pkg::KindSleep, 0, 0, 32'hffff_ffff, 0, 0));
    directed_reqs.push_back(make_req(pts_pkg::KindSleep, 0, 0, 1, 0, 0));
    directed_reqs.push_back(make_req(pts_pkg::KindTick, 0, 0, 0, 0, 0));
    directed_reqs.push_back(make_req(pts_pkg::KindKillId, 8'd3, 0, 0, 0, 0));
    directed_reqs.push_back(make_req(pts_pkg::KindKillSelf, 0, 0, 0, 0, 0));
    directed_reqs.push_back(make_req(pts_pkg::KindKillId, 8'hee, 0, 0, 0, 0));
    foreach (directed_reqs[i]) send_req(directed_reqs[i]);

    // random part; the receiver holds off once along the way
    for (int n = 0; n < 930; n++) begin
      if (n == 300) hold_off = 1;
      if (n == 850) quiet_phase = 1;
      r = rand_req();
      send_req(r);
    end
    stim_done = 1;
  end

  // receiver side
  initial begin
    out_ready_i = 0;
    hold_off = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ready_i = 0;
        repeat (200) @(negedge clk_i);
        hold_off = 0;
      end
      if (!quiet_phase && $urandom_range(0, 99) < 20) begin
        out_ready_i = 0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk_i);
      end else begin
        out_ready_i = 1;
      end
    end
  end

  // result checking
  always @(posedge clk_i) begin
    sched_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing pending");
      end else begin
        exp_res = pending_results.pop_front();
        if (status_o !== exp_res.status || running_slot_o !== exp_res.slot ||
            running_id_o !== exp_res.id || fired_mask_o !== exp_res.fired ||
            thread_count_o !== exp_res.count || time_now_o !== exp_res.now) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %0d %0d %0d %h %0d %0d got %0d %0d %0d %h %0d %0d",
                     exp_res.status, exp_res.slot, exp_res.id, exp_res.fired,
                     exp_res.count, exp_res.now, status_o, running_slot_o, running_id_o,
                     fired_mask_o, thread_count_o, time_now_o);
        end
      end
    end
  end

  // end of run
  initial begin
    mismatches = 0;
    wait (stim_done);
    wait (pending_results.size() == 0);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_priority_thread_scheduler OK");
    end else begin
      $display("tb_priority_thread_scheduler NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("tb_priority_thread_scheduler NOT OK");
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/pts_pkg.sv
sv/priority_thread_scheduler.sv
tb/tb_priority_thread_scheduler.sv
